// ----- rtl/core/four_level_page_table_mapper_assert.svh -----
// Assertion macros for the four-level page table mapper.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define FLPTM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define FLPTM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FLPTM_CHECK(lbl, prop, msg)
`define FLPTM_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/flptm_pkg.sv -----
// Shared constants, types and helpers of the four-level page table mapper.
package flptm_pkg;

  localparam int UPPER_PAGES_DEF      = 1;
  localparam int MIDDLE_PAGES_DEF     = 1;
  localparam int LEAF_TABLE_PAGES_DEF = 4;
  localparam int POOL_PAGES_DEF       = 8;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int ENTRY_W           = 64;
  localparam int PAGE_ADDR_LSB     = 12;

  typedef logic [ENTRY_W-1:0] entry_t;

  localparam entry_t LINK_BITS     = 64'h0000_0000_0000_0003;
  localparam entry_t BIT_WT        = 64'h0000_0000_0000_0008;
  localparam entry_t BIT_CD        = 64'h0000_0000_0000_0010;
  localparam entry_t BIT_LARGE     = 64'h0000_0000_0000_0080;
  localparam entry_t FRAME_4K_MASK = 64'h000f_ffff_ffff_f000;
  localparam entry_t FRAME_2M_MASK = 64'h000f_ffff_ffe0_0000;

  localparam logic       ACT_CREATE = 1'b0;
  localparam logic [1:0] SZ_2M      = 2'd1;

  typedef enum logic [1:0] {
    LV_TOP    = 2'd0,
    LV_UPPER  = 2'd1,
    LV_MIDDLE = 2'd2,
    LV_LEAF   = 2'd3
  } level_t;

  // Directory link to a store page: page address with present and rw set.
  function automatic entry_t link_entry(input logic [15:0] page);
    entry_t e;
    e = {36'b0, page, 12'b0} | LINK_BITS;
    return e;
  endfunction

endpackage

// ----- rtl/core/flptm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module flptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 7680
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/four_level_page_table_mapper.sv -----
// Top level of the four-level page table mapper: walk sequencer over the table store.
//
// Requests arrive on the s_axis channel, one beat per create or delete; each
// request gives exactly one result beat on the m_axis channel.
// A request walks up to four table levels. Each level has a store read
// state and an evaluate state, in which a directory fill, a large entry or a
// leaf update is written back to the same store slot. A request that fails
// early returns without walking the remaining levels. The single store port
// means that the levels are read strictly one after another.
// One request is in flight at a time; s_axis_tready is high whenever the
// sequencer is idle, also while an earlier result waits on m_axis.
// After reset the store is swept once, one entry a cycle, to zeros and the
// preset directory links: all TOTAL_PAGES * 512 entries (7680 at the default
// sizes); no request is taken during the sweep.
// When m_axis_tready stays low, the result holds in the output register and
// a finished second request waits in the sequencer until the register frees.
module four_level_page_table_mapper #(
  parameter int UPPER_PAGES      = flptm_pkg::UPPER_PAGES_DEF,
  parameter int MIDDLE_PAGES     = flptm_pkg::MIDDLE_PAGES_DEF,
  parameter int LEAF_TABLE_PAGES = flptm_pkg::LEAF_TABLE_PAGES_DEF,
  parameter int POOL_PAGES       = flptm_pkg::POOL_PAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[0], virt_addr[48:1], phys_addr[100:49], size_code[102:101],
  // write_through[103], cache_off[104], zero fill[111:105]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[0], tlb_flush[1], flush_addr[49:2], zero fill[55:50]
  output logic [55:0]  m_axis_tdata
);

  `include "four_level_page_table_mapper_assert.svh"

  localparam int TOTAL_PAGES  = 1 + UPPER_PAGES + MIDDLE_PAGES + LEAF_TABLE_PAGES + POOL_PAGES;
  localparam int DEPTH        = TOTAL_PAGES * flptm_pkg::ENTRIES_PER_TABLE;
  localparam int AW           = $clog2(DEPTH);
  localparam int IW           = flptm_pkg::IDX_W;
  localparam int PW           = AW - IW;
  localparam int CW           = $clog2(POOL_PAGES + 1);
  localparam int UPPER_FIRST  = 1;
  localparam int MIDDLE_FIRST = UPPER_FIRST + UPPER_PAGES;
  localparam int LEAF_FIRST   = MIDDLE_FIRST + MIDDLE_PAGES;
  localparam int POOL_FIRST   = LEAF_FIRST + LEAF_TABLE_PAGES;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  flptm_pkg::level_t level;
  logic [AW-1:0]     clr_addr;
  logic [PW-1:0]     page;
  logic [CW-1:0]     pool_used;

  logic              act;
  logic [47:0]       va;
  logic [51:0]       pa;
  logic [1:0]        size;
  logic              wt;
  logic              cd;
  logic              res_ok;
  logic              res_flush;

  logic              out_status;
  logic              out_flush;
  logic [47:0]       out_faddr;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_addr;
  flptm_pkg::entry_t     ram_wdata;
  flptm_pkg::entry_t     rd;

  logic [IW-1:0]         idx;
  logic [AW-1:0]         slot_addr;
  logic [PW-1:0]         clr_pg;
  logic [IW-1:0]         clr_ix;
  flptm_pkg::entry_t     init_entry;
  flptm_pkg::entry_t     attr;
  flptm_pkg::entry_t     ev_wdata;
  logic                  ev_we;
  logic                  ev_fail;
  logic                  ev_done;
  logic                  ev_flush;
  logic                  ev_take;
  logic [PW-1:0]         ev_page;
  logic                  link_ok;
  logic                  rd_zero;
  logic                  ptr_ok;
  logic                  pool_avail;
  logic [PW-1:0]         pool_page;
  logic                  out_free;
  logic                  accept;

  flptm_ram #(
    .WIDTH (flptm_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd)
  );

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {6'b0, out_faddr, out_flush, out_status};

  always_comb begin
    unique case (level)
      flptm_pkg::LV_TOP:    idx = va[47:39];
      flptm_pkg::LV_UPPER:  idx = va[38:30];
      flptm_pkg::LV_MIDDLE: idx = va[29:21];
      flptm_pkg::LV_LEAF:   idx = va[20:12];
      default:              idx = va[20:12];
    endcase
  end

  assign slot_addr = {page, idx};

  // Reset image of the store: preset directory links, zeros elsewhere.
  assign clr_pg = clr_addr[AW-1:IW];
  assign clr_ix = clr_addr[IW-1:0];

  always_comb begin
    init_entry = '0;
    if (clr_pg == PW'(0) && clr_ix < IW'(UPPER_PAGES)) begin
      init_entry = flptm_pkg::link_entry(16'(PW'(UPPER_FIRST) + clr_ix[PW-1:0]));
    end else if (clr_pg == PW'(UPPER_FIRST) && clr_ix < IW'(MIDDLE_PAGES)) begin
      init_entry = flptm_pkg::link_entry(16'(PW'(MIDDLE_FIRST) + clr_ix[PW-1:0]));
    end else if (clr_pg == PW'(MIDDLE_FIRST) && clr_ix < IW'(LEAF_TABLE_PAGES)) begin
      init_entry = flptm_pkg::link_entry(16'(PW'(LEAF_FIRST) + clr_ix[PW-1:0]));
    end
  end

  assign link_ok    = (rd[1:0] != 2'b00);
  assign rd_zero    = (rd == '0);
  assign ptr_ok     = (rd[11:8] == 4'b0) && (rd[63:12] < 52'(TOTAL_PAGES));
  assign pool_avail = (pool_used < CW'(POOL_PAGES));
  assign pool_page  = PW'(POOL_FIRST) + PW'(pool_used);
  assign attr       = (wt ? flptm_pkg::BIT_WT : '0) | (cd ? flptm_pkg::BIT_CD : '0);

  // Evaluate one level: check, fill, or write the final entry.
  always_comb begin
    ev_we    = 1'b0;
    ev_wdata = rd;
    ev_fail  = 1'b0;
    ev_done  = 1'b0;
    ev_flush = 1'b0;
    ev_take  = 1'b0;
    ev_page  = rd[flptm_pkg::PAGE_ADDR_LSB +: PW];
    unique case (level)
      flptm_pkg::LV_TOP: begin
        if ((act == flptm_pkg::ACT_CREATE && size > flptm_pkg::SZ_2M) || !link_ok || !ptr_ok) begin
          ev_fail = 1'b1;
        end
      end
      flptm_pkg::LV_UPPER, flptm_pkg::LV_MIDDLE: begin
        if (act == flptm_pkg::ACT_CREATE && level == flptm_pkg::LV_MIDDLE && rd_zero &&
            size == flptm_pkg::SZ_2M) begin
          ev_we    = 1'b1;
          ev_wdata = ({12'b0, pa} & flptm_pkg::FRAME_2M_MASK) | flptm_pkg::BIT_LARGE | attr |
                     flptm_pkg::LINK_BITS;
          ev_done  = 1'b1;
        end else if (act == flptm_pkg::ACT_CREATE && rd_zero) begin
          if (!pool_avail) begin
            ev_fail = 1'b1;
          end else begin
            ev_we    = 1'b1;
            ev_wdata = flptm_pkg::link_entry(16'(pool_page));
            ev_take  = 1'b1;
            ev_page  = pool_page;
          end
        end else if (!link_ok || !ptr_ok) begin
          ev_fail = 1'b1;
        end
      end
      flptm_pkg::LV_LEAF: begin
        if (act == flptm_pkg::ACT_CREATE) begin
          if (link_ok) begin
            ev_fail = 1'b1;
          end else begin
            ev_we    = 1'b1;
            ev_wdata = ({12'b0, pa} & flptm_pkg::FRAME_4K_MASK) | flptm_pkg::LINK_BITS | attr;
            ev_done  = 1'b1;
            ev_flush = 1'b1;
          end
        end else if (!link_ok) begin
          ev_fail = 1'b1;
        end else begin
          ev_we    = 1'b1;
          ev_wdata = rd & ~(flptm_pkg::FRAME_4K_MASK | flptm_pkg::LINK_BITS);
          ev_done  = 1'b1;
          ev_flush = 1'b1;
        end
      end
      default: ev_fail = 1'b1;
    endcase
  end

  assign ram_re    = (state == ST_READ);
  assign ram_we    = (state == ST_CLEAR) || ((state == ST_EVAL) && ev_we);
  assign ram_addr  = (state == ST_CLEAR) ? clr_addr : slot_addr;
  assign ram_wdata = (state == ST_CLEAR) ? init_entry : ev_wdata;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = ST_EVAL;
      ST_EVAL:  state_next = (ev_fail || ev_done) ? ST_DONE : ST_READ;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      pool_used     <= '0;
      level         <= flptm_pkg::LV_TOP;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept) begin
        level <= flptm_pkg::LV_TOP;
      end else if (state == ST_EVAL && !ev_fail && !ev_done) begin
        level <= flptm_pkg::level_t'(level + 2'd1);
      end
      if (state == ST_EVAL && ev_take) begin
        pool_used <= pool_used + CW'(1);
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= s_axis_tdata[0];
      va   <= s_axis_tdata[48:1];
      pa   <= s_axis_tdata[100:49];
      size <= s_axis_tdata[102:101];
      wt   <= s_axis_tdata[103];
      cd   <= s_axis_tdata[104];
      page <= '0;
    end else if (state == ST_EVAL) begin
      page      <= ev_page;
      res_ok    <= !ev_fail;
      res_flush <= ev_flush && !ev_fail;
    end
    if (state == ST_DONE && out_free) begin
      out_status <= !res_ok;
      out_flush  <= res_flush;
      out_faddr  <= res_flush ? va : 48'b0;
    end
  end

  `FLPTM_CHECK(a_flush_needs_ok, (m_axis_tvalid && out_flush) |-> !out_status, "failed flush")
  `FLPTM_CHECK(a_faddr_zero, (m_axis_tvalid && !out_flush) |-> out_faddr == 48'b0, "stray addr")
  `FLPTM_CHECK(a_pool_bound, pool_used <= CW'(POOL_PAGES), "pool count beyond pool size")
  `FLPTM_CHECK(a_write_place, ram_we |-> (state == ST_CLEAR || state == ST_EVAL), "stray write")
  `FLPTM_CHECK_NEXT(a_accept_reads, accept,
                    state == ST_READ && level == flptm_pkg::LV_TOP, "walk not at top")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the four-level page table mapper: random and directed map/unmap beats.
`timescale 1ns / 100ps

module tb_top;

  localparam int TABLE_PAGES = 1 + flptm_pkg::UPPER_PAGES_DEF + flptm_pkg::MIDDLE_PAGES_DEF
                               + flptm_pkg::LEAF_TABLE_PAGES_DEF + flptm_pkg::POOL_PAGES_DEF;
  localparam int UPPER_BASE  = 1;
  localparam int MIDDLE_BASE = UPPER_BASE + flptm_pkg::UPPER_PAGES_DEF;
  localparam int LEAF_BASE   = MIDDLE_BASE + flptm_pkg::MIDDLE_PAGES_DEF;
  localparam int POOL_BASE   = LEAF_BASE + flptm_pkg::LEAF_TABLE_PAGES_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 1100;

  localparam logic       ACT_DELETE = 1'b1;
  localparam logic [1:0] SZ_4K      = 2'd0;
  localparam logic [1:0] SZ_BAD     = 2'd2;
  localparam logic [1:0] SZ_BAD_HI  = 2'd3;
  localparam logic       ST_OK      = 1'b0;
  localparam logic       ST_FAIL    = 1'b1;

  typedef struct {
    logic        act;
    logic [47:0] va;
    logic [51:0] pa;
    logic [1:0]  sz;
    logic        wt;
    logic        cd;
  } map_req_t;

  typedef struct {
    logic        status;
    logic        flush;
    logic [47:0] faddr;
  } map_rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;

  flptm_pkg::entry_t table_copy [TABLE_PAGES * flptm_pkg::ENTRIES_PER_TABLE];
  int       pool_pages_taken;
  map_req_t request_queue[$];
  map_rsp_t awaited_outcomes[$];
  map_req_t cur_req;
  logic     in_acc = 1'b0;
  int       err_count = 0;
  int       cycle_count = 0;
  int       results_seen = 0;
  int       tx_gap = 0;
  bit       tx_calm = 0;
  int       rx_hold = 0;
  bit       rx_calm = 0;
  bit       backlog_done = 0;

  four_level_page_table_mapper uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic flptm_pkg::entry_t page_link(input int pg);
    return (flptm_pkg::entry_t'(pg) << flptm_pkg::PAGE_ADDR_LSB) | flptm_pkg::LINK_BITS;
  endfunction

  function automatic int slot_of(input int pg, input logic [8:0] idx);
    return pg * flptm_pkg::ENTRIES_PER_TABLE + int'(idx);
  endfunction

  function automatic bit ptr_page(input flptm_pkg::entry_t e, output int pg);
    flptm_pkg::entry_t base;
    base = e & ~flptm_pkg::entry_t'(8'hff);
    pg = 0;
    if (base[11:8] != 4'd0) return 1'b0;
    if ((base >> flptm_pkg::PAGE_ADDR_LSB) >= TABLE_PAGES) return 1'b0;
    pg = int'(base >> flptm_pkg::PAGE_ADDR_LSB);
    return 1'b1;
  endfunction

  function automatic bit claim_or_check(input int s);
    if (table_copy[s] == '0) begin
      if (pool_pages_taken >= flptm_pkg::POOL_PAGES_DEF) return 1'b0;
      table_copy[s] = page_link(POOL_BASE + pool_pages_taken);
      pool_pages_taken++;
      return 1'b1;
    end
    return (table_copy[s] & flptm_pkg::LINK_BITS) != '0;
  endfunction

  function automatic bit map_create(input map_req_t r, output bit flush);
    flptm_pkg::entry_t attr;
    flptm_pkg::entry_t pa_ext;
    int                pg;
    int                s;
    logic [8:0]        i4;
    flush = 1'b0;
    i4 = r.va[47:39];
    attr = (r.wt ? flptm_pkg::BIT_WT : '0) | (r.cd ? flptm_pkg::BIT_CD : '0);
    pa_ext = {12'b0, r.pa};
    if (r.sz != SZ_4K && r.sz != flptm_pkg::SZ_2M) return 1'b0;
    if ((table_copy[i4] & flptm_pkg::LINK_BITS) == '0) return 1'b0;
    if (!ptr_page(table_copy[i4], pg)) return 1'b0;
    s = slot_of(pg, r.va[38:30]);
    if (!claim_or_check(s)) return 1'b0;
    if (!ptr_page(table_copy[s], pg)) return 1'b0;
    s = slot_of(pg, r.va[29:21]);
    if (table_copy[s] == '0 && r.sz == flptm_pkg::SZ_2M) begin
      table_copy[s] = (pa_ext & flptm_pkg::FRAME_2M_MASK) | flptm_pkg::BIT_LARGE | attr
                      | flptm_pkg::LINK_BITS;
      return 1'b1;
    end
    if (!claim_or_check(s)) return 1'b0;
    if (!ptr_page(table_copy[s], pg)) return 1'b0;
    s = slot_of(pg, r.va[20:12]);
    if ((table_copy[s] & flptm_pkg::LINK_BITS) != '0) return 1'b0;
    table_copy[s] = (pa_ext & flptm_pkg::FRAME_4K_MASK) | flptm_pkg::LINK_BITS | attr;
    flush = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit map_delete(input map_req_t r);
    int         pg;
    int         s;
    logic [8:0] i4;
    i4 = r.va[47:39];
    if ((table_copy[i4] & flptm_pkg::LINK_BITS) == '0 || !ptr_page(table_copy[i4], pg))
      return 1'b0;
    s = slot_of(pg, r.va[38:30]);
    if ((table_copy[s] & flptm_pkg::LINK_BITS) == '0 || !ptr_page(table_copy[s], pg))
      return 1'b0;
    s = slot_of(pg, r.va[29:21]);
    if ((table_copy[s] & flptm_pkg::LINK_BITS) == '0 || !ptr_page(table_copy[s], pg))
      return 1'b0;
    s = slot_of(pg, r.va[20:12]);
    if ((table_copy[s] & flptm_pkg::LINK_BITS) == '0) return 1'b0;
    table_copy[s] = table_copy[s] & ~(flptm_pkg::FRAME_4K_MASK | flptm_pkg::LINK_BITS);
    return 1'b1;
  endfunction

  function automatic void walk_and_update(input map_req_t r);
    map_rsp_t want;
    bit       ok;
    bit       fl;
    fl = 1'b0;
    if (r.act == flptm_pkg::ACT_CREATE) begin
      ok = map_create(r, fl);
    end else begin
      ok = map_delete(r);
      fl = ok;
    end
    want.status = ok ? ST_OK : ST_FAIL;
    want.flush = ok && fl;
    want.faddr = want.flush ? r.va : '0;
    awaited_outcomes.push_back(want);
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result(input logic [55:0] beat);
    map_rsp_t want;
    if (awaited_outcomes.size() == 0) begin
      report_mismatch("unexpected beat", beat[47:0], '0);
    end else begin
      want = awaited_outcomes.pop_front();
      if (beat[0] !== want.status) report_mismatch("status", 48'(beat[0]), 48'(want.status));
      if (beat[1] !== want.flush) report_mismatch("tlb_flush", 48'(beat[1]), 48'(want.flush));
      if (beat[49:2] !== want.faddr) report_mismatch("flush_addr", beat[49:2], want.faddr);
    end
  endtask

  function automatic void add_req(input logic act, input logic [47:0] va, input logic [51:0] pa,
                                  input logic [1:0] sz, input logic wt, input logic cd);
    map_req_t r;
    r.act = act;
    r.va = va;
    r.pa = pa;
    r.sz = sz;
    r.wt = wt;
    r.cd = cd;
    request_queue.push_back(r);
  endfunction

  function automatic logic [47:0] va_of(input logic [8:0] i4, input logic [8:0] i3,
                                        input logic [8:0] i2, input logic [8:0] i1);
    return {i4, i3, i2, i1, 12'h000};
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drive request beats
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (in_acc || !s_axis_tvalid) begin
      if (in_acc && $urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (in_acc && !tx_calm && $urandom_range(0, 2) == 0) tx_gap = idle_len();
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        cur_req = request_queue.pop_front();
        s_axis_tdata <= {7'b0, cur_req.cd, cur_req.wt, cur_req.sz, cur_req.pa, cur_req.va,
                         cur_req.act};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure, with one long hold to fill the block
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (!backlog_done && results_seen >= 200) begin
      backlog_done = 1;
      rx_hold = 300;
      m_axis_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      rx_hold = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      in_acc <= !rst && s_axis_tvalid && s_axis_tready;
      if (!rst && s_axis_tvalid && s_axis_tready) walk_and_update(cur_req);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        results_seen++;
      end
    end
  end

  initial begin
    map_req_t   r;
    logic [8:0] i4;
    logic [8:0] i3;
    logic [8:0] i2;
    logic [8:0] i1;
    int         roll;

    foreach (table_copy[k]) table_copy[k] = '0;
    for (int k = 0; k < flptm_pkg::UPPER_PAGES_DEF; k++)
      table_copy[k] = page_link(UPPER_BASE + k);
    for (int k = 0; k < flptm_pkg::MIDDLE_PAGES_DEF; k++)
      table_copy[UPPER_BASE * flptm_pkg::ENTRIES_PER_TABLE + k] = page_link(MIDDLE_BASE + k);
    for (int k = 0; k < flptm_pkg::LEAF_TABLE_PAGES_DEF; k++)
      table_copy[MIDDLE_BASE * flptm_pkg::ENTRIES_PER_TABLE + k] = page_link(LEAF_BASE + k);
    pool_pages_taken = 0;

    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 0, 0), '1, SZ_4K, 1'b1, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 0, 0) | 48'hfff, '0, SZ_4K, 1'b0, 1'b0);
    add_req(ACT_DELETE, va_of(0, 0, 0, 0), '0, SZ_4K, 1'b0, 1'b0);
    add_req(ACT_DELETE, va_of(0, 0, 0, 0), '0, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 0, 0), '0, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 0, 7), '1, SZ_BAD, 1'b1, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 0, 7), '1, SZ_BAD_HI, 1'b0, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(1, 0, 0, 0), 52'h1_2345_6789_a000, SZ_4K, 1'b0, 1'b0);
    add_req(ACT_DELETE, '1, '1, SZ_BAD_HI, 1'b1, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 10, 0), '1, flptm_pkg::SZ_2M, 1'b1, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 10, 3), 52'h1234_5678_9000, SZ_4K, 1'b0, 1'b0);
    add_req(ACT_DELETE, va_of(0, 0, 10, 3), '0, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 1, 0), 52'ha_bcde_f012_3456, flptm_pkg::SZ_2M,
            1'b0, 1'b1);
    // large entry with a low frame points back at the top table
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 100, 0), 52'h1f_ffff, flptm_pkg::SZ_2M,
            1'b0, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 100, 5), 52'h3000, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(5, 0, 0, 0), 52'h5000, SZ_4K, 1'b0, 1'b0);
    add_req(ACT_DELETE, va_of(0, 0, 100, 5), '0, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(5, 0, 0, 0), 52'h5000, SZ_4K, 1'b0, 1'b0);
    // drain the pool down to exhaustion
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 1, 0, 0), 52'h7_0000_1000, SZ_4K, 1'b1, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 2, 0, 0), 52'h7_0000_2000, SZ_4K, 1'b0, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 3, 0, 0), 52'h7_0000_3000, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 0, 4, 0), 52'h7_0000_4000, SZ_4K, 1'b1, 1'b1);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 4, 0, 0), 52'h7_0000_5000, SZ_4K, 1'b0, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 4, 0, 0), 52'h7_0060_0000, flptm_pkg::SZ_2M,
            1'b1, 1'b0);
    add_req(flptm_pkg::ACT_CREATE, va_of(0, 5, 0, 0), 52'h7_0000_6000, SZ_4K, 1'b0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        r.act = 1'($urandom_range(0, 1));
        r.va = 48'({$urandom(), $urandom()});
        r.sz = 2'($urandom_range(0, 3));
      end else begin
        r.act = ($urandom_range(0, 99) < 55) ? flptm_pkg::ACT_CREATE : ACT_DELETE;
        i4 = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 511)) : 9'd0;
        i3 = 9'($urandom_range(0, 5));
        if ($urandom_range(0, 99) < 75) begin
          i2 = 9'($urandom_range(0, 5));
        end else begin
          do i2 = 9'($urandom_range(0, 511)); while (i2 == 9'd100);
        end
        i1 = 9'($urandom_range(0, 31));
        r.va = {i4, i3, i2, i1, 12'($urandom())};
        roll = $urandom_range(0, 99);
        if (roll < 60) r.sz = SZ_4K;
        else if (roll < 92) r.sz = flptm_pkg::SZ_2M;
        else r.sz = 2'($urandom_range(2, 3));
      end
      r.pa = 52'({$urandom(), $urandom()});
      if (r.sz == flptm_pkg::SZ_2M && r.pa[51:21] == '0) r.pa[40] = 1'b1;
      r.wt = 1'($urandom_range(0, 1));
      r.cd = 1'($urandom_range(0, 1));
      request_queue.push_back(r);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (request_queue.size() != 0 || s_axis_tvalid || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && awaited_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- four_level_page_table_mapper.f -----
+incdir+rtl/core
rtl/core/flptm_pkg.sv
rtl/core/flptm_ram.sv
rtl/core/four_level_page_table_mapper.sv
bench/tb_top.sv
